// ===== src/text_cell_run_packer_macros.svh =====
// Assertion macros shared by the packer RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef TEXT_CELL_RUN_PACKER_MACROS_SVH
`define TEXT_CELL_RUN_PACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr holds at every clock edge out of reset
`define TCRP_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tcrp: invariant violated");

// cons holds in the same cycle as ante
`define TCRP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcrp: implication violated");

// cons holds in the cycle after ante
`define TCRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcrp: next-cycle check violated");

`else

`define TCRP_ASSERT_ALWAYS(label, expr)
`define TCRP_ASSERT_IMPLY(label, ante, cons)
`define TCRP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/tcrp_pkg.sv =====
package tcrp_pkg;

    // field widths
    localparam int POS_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 16;
    localparam int ID_W    = 12;
    localparam int LEN_W   = 4;
    localparam int BASE_W  = 11;

    // character slots in a frame, and the held-count width (0..SLOTS)
    localparam int SLOTS               = 6;
    localparam int CHARS_PER_FRAME_DEF = 6;
    localparam int CNT_W               = 3;

    // identifier composition
    localparam logic [ID_W-1:0]  ID_BASE_MASK    = 12'hF00;
    localparam logic [ID_W-1:0]  ID_COL_MASK     = 12'h0F0;
    localparam logic [ID_W-1:0]  ID_ROW_MASK     = 12'h00F;
    localparam logic [LEN_W-1:0] LEN_COLOR_BYTES = 4'd2;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int FCNT_W     = 3;

    // register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_FRAME_ID_BASE = 1'b0;

    typedef logic [SLOTS-1:0][BYTE_W-1:0] char_slots_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] fore_byte;
        logic [BYTE_W-1:0] back_byte;
        char_slots_t       chars;
        logic              last;
    } frame_t;

    typedef struct packed {
        logic has_room;   // at least two free entries
        logic not_empty;
    } fifo_stat_t;

    // RGB565 to 3-2-3: R[15:13], G[10:9], B[4:2]
    function automatic logic [BYTE_W-1:0] reduce_color(input logic [COLOR_W-1:0] c);
        return {c[15:13], c[10:9], c[4:2]};
    endfunction

    // assemble a frame, zeroing slots at or above the character count
    function automatic frame_t build_frame(
        input logic [ID_W-1:0]    id,
        input logic [CNT_W-1:0]   cnt,
        input logic [COLOR_W-1:0] fore,
        input logic [COLOR_W-1:0] back,
        input char_slots_t        chars,
        input logic               last
    );
        frame_t f;
        f.id        = id;
        f.length    = LEN_COLOR_BYTES + LEN_W'(cnt);
        f.fore_byte = reduce_color(fore);
        f.back_byte = reduce_color(back);
        for (int i = 0; i < SLOTS; i++) begin
            f.chars[i] = (CNT_W'(i) < cnt) ? chars[i] : '0;
        end
        f.last      = last;
        return f;
    endfunction

endpackage

// ===== src/tcrp_if.sv =====
// Text cell channel
interface cell_if;
    logic                           valid;
    logic                           ready;
    logic [tcrp_pkg::POS_W-1:0]     cell_column;
    logic [tcrp_pkg::POS_W-1:0]     cell_row;
    logic [tcrp_pkg::BYTE_W-1:0]    char_code;
    logic [tcrp_pkg::COLOR_W-1:0]   fore_color;
    logic [tcrp_pkg::COLOR_W-1:0]   back_color;
    logic                           end_of_screen;

    modport source (
        output valid, cell_column, cell_row, char_code, fore_color, back_color,
               end_of_screen,
        input  ready
    );
    modport sink (
        input  valid, cell_column, cell_row, char_code, fore_color, back_color,
               end_of_screen,
        output ready
    );
endinterface

// Character frame channel
interface frame_if;
    logic                           valid;
    logic                           ready;
    logic [tcrp_pkg::ID_W-1:0]      frame_id;
    logic [tcrp_pkg::LEN_W-1:0]     frame_length;
    logic [tcrp_pkg::BYTE_W-1:0]    fore_byte;
    logic [tcrp_pkg::BYTE_W-1:0]    back_byte;
    logic [tcrp_pkg::BYTE_W-1:0]    char_0;
    logic [tcrp_pkg::BYTE_W-1:0]    char_1;
    logic [tcrp_pkg::BYTE_W-1:0]    char_2;
    logic [tcrp_pkg::BYTE_W-1:0]    char_3;
    logic [tcrp_pkg::BYTE_W-1:0]    char_4;
    logic [tcrp_pkg::BYTE_W-1:0]    char_5;
    logic                           last_of_run;

    modport source (
        output valid, frame_id, frame_length, fore_byte, back_byte,
               char_0, char_1, char_2, char_3, char_4, char_5, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, frame_id, frame_length, fore_byte, back_byte,
               char_0, char_1, char_2, char_3, char_4, char_5, last_of_run,
        output ready
    );
endinterface

// ===== src/tcrp_frame_fifo.sv =====
`include "text_cell_run_packer_macros.svh"

// Small result queue: takes up to two frames a cycle, gives one.
module tcrp_frame_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_n,
    input  tcrp_pkg::frame_t      push_d0,
    input  tcrp_pkg::frame_t      push_d1,
    input  logic                  pop,
    output tcrp_pkg::frame_t      head,
    output tcrp_pkg::fifo_stat_t  stat
);
    import tcrp_pkg::*;

    frame_t              mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;
    logic [PTR_W-1:0]    wr_ptr_1;

    assign do_pop   = pop && (count_reg != '0);
    assign wr_ptr_1 = wr_ptr_reg + PTR_W'(1);

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + FCNT_W'(push_n) - FCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage writes
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_d0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_1] <= push_d1;
        end
    end

    assign head           = mem[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.has_room  = (count_reg <= FCNT_W'(FIFO_DEPTH - 2));

    `TCRP_ASSERT_ALWAYS(a_fifo_bound, count_reg <= FCNT_W'(FIFO_DEPTH))
    `TCRP_ASSERT_IMPLY(a_fifo_push_room, push_n != 2'd0, count_reg <= FCNT_W'(FIFO_DEPTH - 2))

endmodule

// ===== src/text_cell_run_packer.sv =====
// text_cell_run_packer
// Packs text cells, taken in scan order on the cell channel, into character
// frames on the frame channel. Cells with equal fore/back colors share a
// frame of up to CHARS_PER_FRAME characters; a color change, a full frame
// or an end-of-screen cell sends the pending frame.
// Throughput: one cell per cycle while the queue has room. Each cell is decided in the cycle it is
// accepted; its frames (zero, one or two) are written into a four-entry
// result queue and, behind any frames already queued, show on the frame
// channel from the next cycle on.
// A cell that sends two frames takes two queue entries; the cell channel is
// held off only while the queue has fewer than two free entries, so with a
// stalled receiver cell ready drops as soon as three frames are waiting.
// Reset clears the pending frame, the queue and frame_id_base. The user must
// write frame_id_base (APB port, address 0) only while idle; not enforced.
module text_cell_run_packer #(
    parameter int CHARS_PER_FRAME = tcrp_pkg::CHARS_PER_FRAME_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    cell_if.sink                         cells,
    frame_if.source                      frame,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcrp_pkg::APB_AW-1:0]  paddr,
    input  logic [tcrp_pkg::APB_DW-1:0]  pwdata,
    output logic [tcrp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import tcrp_pkg::*;

    // configuration
    logic [BASE_W-1:0]   base_reg;
    logic                reg_hit;
    logic                cfg_wr;

    // run state
    logic                pending_reg;
    logic [CNT_W-1:0]    held_cnt_reg;
    logic [ID_W-1:0]     held_id_reg;
    logic [COLOR_W-1:0]  held_fore_reg;
    logic [COLOR_W-1:0]  held_back_reg;
    logic [BYTE_W-1:0]   held_chars_reg [CHARS_PER_FRAME];

    // per-cell decision
    logic                acc;
    logic                brk;
    logic                emit_held;
    logic [CNT_W-1:0]    wr_cnt;
    logic [CNT_W-1:0]    cnt_new;
    logic [ID_W-1:0]     new_id;
    logic [ID_W-1:0]     cur_id;
    char_slots_t         held_slots;
    char_slots_t         cur_slots;
    frame_t              frame_held;
    frame_t              frame_cur;

    // queue hookup
    logic [1:0]          push_n;
    frame_t              push_d0;
    frame_t              push_d1;
    frame_t              head;
    fifo_stat_t          fstat;

    // APB register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1:2] == REG_FRAME_ID_BASE);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign prdata  = reg_hit ? APB_DW'(base_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_wr)
        begin
            base_reg <= pwdata[BASE_W-1:0];
        end
    end

    // run break and write position
    assign acc       = cells.valid && cells.ready;
    assign brk       = !pending_reg
                    || (held_cnt_reg >= CNT_W'(CHARS_PER_FRAME))
                    || (cells.fore_color != held_fore_reg)
                    || (cells.back_color != held_back_reg);
    assign emit_held = brk && pending_reg;
    assign wr_cnt    = brk ? '0 : held_cnt_reg;
    assign cnt_new   = wr_cnt + CNT_W'(1);
    assign new_id    = (ID_W'(base_reg) & ID_BASE_MASK)
                     | ({4'h0, cells.cell_column, 4'h0} & ID_COL_MASK)
                     | (ID_W'(cells.cell_row) & ID_ROW_MASK);
    assign cur_id    = brk ? new_id : held_id_reg;

    // slot views of the held frame and of the frame including this cell
    always_comb
    begin
        held_slots = '0;
        cur_slots  = '0;
        for (int i = 0; i < CHARS_PER_FRAME; i++)
        begin
            held_slots[i] = held_chars_reg[i];
            cur_slots[i]  = (wr_cnt == CNT_W'(i)) ? cells.char_code : held_chars_reg[i];
        end
    end

    // result frames; colors of the current frame equal the cell's
    always_comb
    begin
        frame_held = build_frame(held_id_reg, held_cnt_reg, held_fore_reg,
                                 held_back_reg, held_slots, !cells.end_of_screen);
        frame_cur  = build_frame(cur_id, cnt_new, cells.fore_color,
                                 cells.back_color, cur_slots, 1'b1);
        push_n     = 2'd0;
        push_d0    = frame_held;
        push_d1    = frame_cur;
        if (acc)
        begin
            push_n = 2'(emit_held) + 2'(cells.end_of_screen);
            if (!emit_held)
            begin
                push_d0 = frame_cur;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            held_cnt_reg  <= '0;
            held_id_reg   <= '0;
            held_fore_reg <= '0;
            held_back_reg <= '0;
        end
        else if (acc)
        begin
            if (brk)
            begin
                held_id_reg   <= new_id;
                held_fore_reg <= cells.fore_color;
                held_back_reg <= cells.back_color;
            end
            if (cells.end_of_screen)
            begin
                pending_reg  <= 1'b0;
                held_cnt_reg <= '0;
            end
            else
            begin
                pending_reg  <= 1'b1;
                held_cnt_reg <= cnt_new;
            end
        end
    end

    // character storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CHARS_PER_FRAME; i++)
        begin
            if (acc && (wr_cnt == CNT_W'(i)))
            begin
                held_chars_reg[i] <= cells.char_code;
            end
        end
    end

    tcrp_frame_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_n  (push_n),
        .push_d0 (push_d0),
        .push_d1 (push_d1),
        .pop     (frame.ready),
        .head    (head),
        .stat    (fstat)
    );

    // channel hookup
    assign cells.ready        = fstat.has_room;
    assign frame.valid        = fstat.not_empty;
    assign frame.frame_id     = head.id;
    assign frame.frame_length = head.length;
    assign frame.fore_byte    = head.fore_byte;
    assign frame.back_byte    = head.back_byte;
    assign frame.char_0       = head.chars[0];
    assign frame.char_1       = head.chars[1];
    assign frame.char_2       = head.chars[2];
    assign frame.char_3       = head.chars[3];
    assign frame.char_4       = head.chars[4];
    assign frame.char_5       = head.chars[5];
    assign frame.last_of_run  = head.last;

    `TCRP_ASSERT_ALWAYS(a_cnt_range, held_cnt_reg <= CNT_W'(CHARS_PER_FRAME))
    `TCRP_ASSERT_IMPLY(a_idle_no_chars, !pending_reg, held_cnt_reg == '0)
    `TCRP_ASSERT_NEXT(a_eos_flush, acc && cells.end_of_screen, !pending_reg)
    `TCRP_ASSERT_NEXT(a_cell_pends, acc && !cells.end_of_screen, pending_reg && held_cnt_reg != '0)

endmodule

// ===== verif/tb_text_cell_run_packer.sv =====
`timescale 1ns / 100ps

module tb_text_cell_run_packer;

    import tcrp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;
    localparam int RANDOM_PHASES = 6;
    localparam int CELLS_PER_PHASE = 260;
    localparam int MAX_GAP = 13;
    localparam logic [APB_AW-1:0] BASE_ADDR = {REG_FRAME_ID_BASE, 2'b00};

    // one text cell as queued for the driver, with the idle cycles before it
    typedef struct {
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   row;
        logic [BYTE_W-1:0]  ch;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               eos;
        int unsigned        gap;
    } text_cell_t;

    // one character frame as it should leave the block
    typedef struct {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] fore;
        logic [BYTE_W-1:0] back;
        logic [BYTE_W-1:0] chars [SLOTS];
        logic              last;
    } char_frame_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    cell_if  cell_ch ();
    frame_if frame_ch ();

    text_cell_run_packer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cells   (cell_ch),
        .frame   (frame_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // stimulus and expectations
    text_cell_t  cell_todo [$];
    char_frame_t frames_due [$];
    int unsigned cells_queued = 0;
    int unsigned cells_taken = 0;
    int unsigned frames_checked = 0;
    int unsigned double_cells = 0;
    int unsigned base_settings = 0;
    int unsigned mismatches = 0;
    bit          cell_rush = 1'b0;

    // beats seen at the last rising edge, for the falling-edge drivers
    bit cell_beat = 1'b0;
    bit frame_beat = 1'b0;

    // packer model state
    logic [BASE_W-1:0]  base_reg = '0;
    bit                 run_open = 1'b0;
    int unsigned        run_count = 0;
    logic [ID_W-1:0]    run_id = '0;
    logic [COLOR_W-1:0] run_fore = '0;
    logic [COLOR_W-1:0] run_back = '0;
    logic [BYTE_W-1:0]  run_chars [SLOTS];

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // RGB565 down to 3-2-3: top red, top green, upper blue bits
    function automatic logic [BYTE_W-1:0] squeeze_color(input logic [COLOR_W-1:0] c);
        logic [2:0] red;
        logic [1:0] green;
        logic [2:0] blue;
        red   = c[15:13];
        green = c[10:9];
        blue  = c[4:2];
        return {red, green, blue};
    endfunction

    function automatic char_frame_t close_frame();
        char_frame_t f;
        f.id     = run_id;
        f.length = LEN_COLOR_BYTES + LEN_W'(run_count);
        f.fore   = squeeze_color(run_fore);
        f.back   = squeeze_color(run_back);
        for (int k = 0; k < SLOTS; k++)
            f.chars[k] = (k < run_count) ? run_chars[k] : '0;
        f.last   = 1'b0;
        return f;
    endfunction

    // update the run state for one accepted cell and queue its frames
    function automatic void pack_cell(input text_cell_t c);
        int unsigned sent;
        sent = 0;
        if (!run_open || run_count >= CHARS_PER_FRAME_DEF ||
            c.fore != run_fore || c.back != run_back) begin
            if (run_open) begin
                frames_due.push_back(close_frame());
                sent++;
            end
            run_id    = {1'b0, base_reg[10:8], c.column, c.row};
            run_fore  = c.fore;
            run_back  = c.back;
            run_count = 0;
        end
        run_chars[run_count] = c.ch;
        run_count++;
        run_open = 1'b1;
        // end of screen flushes the frame holding this cell
        if (c.eos) begin
            frames_due.push_back(close_frame());
            sent++;
            run_open  = 1'b0;
            run_count = 0;
        end
        if (sent > 0)
            frames_due[frames_due.size() - 1].last = 1'b1;
        if (sent == 2)
            double_cells++;
    endfunction

    // compare one frame beat against the oldest expectation
    task automatic check_frame();
        char_frame_t got;
        char_frame_t want;
        got.id       = frame_ch.frame_id;
        got.length   = frame_ch.frame_length;
        got.fore     = frame_ch.fore_byte;
        got.back     = frame_ch.back_byte;
        got.chars[0] = frame_ch.char_0;
        got.chars[1] = frame_ch.char_1;
        got.chars[2] = frame_ch.char_2;
        got.chars[3] = frame_ch.char_3;
        got.chars[4] = frame_ch.char_4;
        got.chars[5] = frame_ch.char_5;
        got.last     = frame_ch.last_of_run;
        if (frames_due.size() == 0) begin
            report_mismatch("unexpected frame, id", 32'(got.id), '0);
            return;
        end
        want = frames_due.pop_front();
        frames_checked++;
        if (got.id !== want.id)
            report_mismatch("frame_id", 32'(got.id), 32'(want.id));
        if (got.length !== want.length)
            report_mismatch("frame_length", 32'(got.length), 32'(want.length));
        if (got.fore !== want.fore)
            report_mismatch("fore_byte", 32'(got.fore), 32'(want.fore));
        if (got.back !== want.back)
            report_mismatch("back_byte", 32'(got.back), 32'(want.back));
        for (int k = 0; k < SLOTS; k++)
            if (got.chars[k] !== want.chars[k])
                report_mismatch($sformatf("char_%0d", k), 32'(got.chars[k]),
                                32'(want.chars[k]));
        if (got.last !== want.last)
            report_mismatch("last_of_run", 32'(got.last), 32'(want.last));
    endtask

    // monitor: frames are checked before the same edge's cell is predicted
    always @(posedge clk) begin
        if (rst_n) begin
            text_cell_t c;
            cell_beat  <= cell_ch.valid && cell_ch.ready;
            frame_beat <= frame_ch.valid && frame_ch.ready;
            if (frame_ch.valid && frame_ch.ready)
                check_frame();
            if (cell_ch.valid && cell_ch.ready) begin
                c.column = cell_ch.cell_column;
                c.row    = cell_ch.cell_row;
                c.ch     = cell_ch.char_code;
                c.fore   = cell_ch.fore_color;
                c.back   = cell_ch.back_color;
                c.eos    = cell_ch.end_of_screen;
                c.gap    = 0;
                pack_cell(c);
                cells_taken <= cells_taken + 1;
            end
        end
    end

    // cell driver: idle gap first, then hold the beat until it is taken
    int unsigned cell_wait = 0;
    bit          gap_taken = 1'b0;

    always @(negedge clk) begin
        text_cell_t nxt;
        if (!rst_n) begin
            cell_ch.valid         <= 1'b0;
            cell_ch.cell_column   <= '0;
            cell_ch.cell_row      <= '0;
            cell_ch.char_code     <= '0;
            cell_ch.fore_color    <= '0;
            cell_ch.back_color    <= '0;
            cell_ch.end_of_screen <= 1'b0;
        end else if (!cell_ch.valid || cell_beat) begin
            if (cell_wait > 0) begin
                cell_ch.valid <= 1'b0;
                cell_wait     <= cell_wait - 1;
            end else if (cell_todo.size() > 0) begin
                if (!gap_taken && cell_todo[0].gap != 0) begin
                    cell_ch.valid <= 1'b0;
                    cell_wait     <= cell_todo[0].gap - 1;
                    gap_taken     <= 1'b1;
                end else begin
                    nxt = cell_todo.pop_front();
                    cell_ch.cell_column   <= nxt.column;
                    cell_ch.cell_row      <= nxt.row;
                    cell_ch.char_code     <= nxt.ch;
                    cell_ch.fore_color    <= nxt.fore;
                    cell_ch.back_color    <= nxt.back;
                    cell_ch.end_of_screen <= nxt.eos;
                    cell_ch.valid         <= 1'b1;
                    gap_taken             <= 1'b0;
                end
            end else begin
                cell_ch.valid <= 1'b0;
            end
        end
    end

    // frame receiver: a fresh stall drawn after every beat, with rush stretches
    int unsigned stall_left = 0;
    int unsigned frames_taken = 0;
    bit          ready_started = 1'b0;
    bit          frame_rush = 1'b0;

    always @(negedge clk) begin
        int unsigned n;
        if (!rst_n) begin
            frame_ch.ready <= 1'b0;
        end else if (frame_beat || !ready_started) begin
            ready_started <= 1'b1;
            frames_taken  <= frames_taken + 1;
            if (frames_taken % 40 == 0)
                frame_rush <= ($urandom_range(0, 3) == 0);
            n = frame_rush ? 0 : $urandom_range(0, MAX_GAP);
            if (n == 0) begin
                frame_ch.ready <= 1'b1;
            end else begin
                frame_ch.ready <= 1'b0;
                stall_left     <= n - 1;
            end
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            frame_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat on either channel
    int unsigned quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((cell_ch.valid && cell_ch.ready) || (frame_ch.valid && frame_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t ns: no beat for %0d cycles, %0d frames outstanding",
                         $time, QUIET_LIMIT, frames_due.size());
                $display("tb_text_cell_run_packer NOT OK");
                $finish;
            end
        end
    end

    task automatic add_cell(input logic [POS_W-1:0] column, input logic [POS_W-1:0] row,
                            input logic [BYTE_W-1:0] ch, input logic [COLOR_W-1:0] fore,
                            input logic [COLOR_W-1:0] back, input logic eos);
        text_cell_t c;
        c.column = column;
        c.row    = row;
        c.ch     = ch;
        c.fore   = fore;
        c.back   = back;
        c.eos    = eos;
        c.gap    = cell_rush ? 0 : $urandom_range(0, MAX_GAP);
        cell_todo.push_back(c);
        cells_queued++;
    endtask

    // one screen scan: runs over a small palette, some noise and stray flushes
    task automatic queue_screen();
        logic [COLOR_W-1:0] pal_fore [4];
        logic [COLOR_W-1:0] pal_back [4];
        logic [COLOR_W-1:0] f;
        logic [COLOR_W-1:0] b;
        logic [7:0]         pos;
        logic [7:0]         at;
        int unsigned        cells;
        int unsigned        run_len;
        int unsigned        k;
        int unsigned        idx;
        cells     = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : $urandom_range(20, 120);
        cell_rush = ($urandom_range(0, 3) == 0);
        for (int p = 0; p < 4; p++) begin
            pal_fore[p] = 16'($urandom_range(0, 16'hFFFF));
            pal_back[p] = 16'($urandom_range(0, 16'hFFFF));
        end
        // pairs that differ in only one color
        pal_back[1] = pal_back[0];
        pal_fore[2] = pal_fore[0];
        pos = 8'($urandom_range(0, 255));
        k = 0;
        while (k < cells) begin
            run_len = $urandom_range(1, 9);
            idx = $urandom_range(0, 3);
            f = pal_fore[idx];
            b = pal_back[idx];
            if ($urandom_range(0, 7) == 0) begin
                f = 16'($urandom_range(0, 16'hFFFF));
                b = 16'($urandom_range(0, 16'hFFFF));
            end
            for (int j = 0; j < run_len && k < cells; j++) begin
                at = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : pos;
                add_cell(at[3:0], at[7:4], 8'($urandom_range(0, 255)), f, b,
                         (k == cells - 1) || ($urandom_range(0, 59) == 0));
                pos++;
                k++;
            end
        end
    endtask

    // register write plus read-back over APB
    task automatic write_base(input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        base_reg = value[BASE_W-1:0];
        base_settings++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== APB_DW'(value[BASE_W-1:0]))
            report_mismatch("frame_id_base read-back", prdata, APB_DW'(value[BASE_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait for every queued cell and every expected frame, then settle
    task automatic drain();
        while (cells_taken != cells_queued || frames_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // main sequence
    initial begin
        logic [APB_DW-1:0] plan [RANDOM_PHASES];
        int unsigned       goal;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: all-ones base, full frame, color breaks, flushes
        write_base(32'h0000_07FF);
        add_cell(4'h0, 4'h0, 8'h00, 16'h0000, 16'h0000, 1'b0);
        add_cell(4'h1, 4'h0, 8'hFF, 16'h0000, 16'h0000, 1'b0);
        add_cell(4'h2, 4'h0, 8'h55, 16'h0000, 16'h0000, 1'b0);
        add_cell(4'h3, 4'h0, 8'hAA, 16'h0000, 16'h0000, 1'b0);
        add_cell(4'h4, 4'h0, 8'h01, 16'h0000, 16'h0000, 1'b0);
        add_cell(4'h5, 4'h0, 8'h80, 16'h0000, 16'h0000, 1'b0);
        // seventh cell with equal colors: frame full
        add_cell(4'hF, 4'hF, 8'h7F, 16'h0000, 16'h0000, 1'b0);
        // fore changes only, then back changes only together with end of screen
        add_cell(4'hF, 4'h0, 8'hFE, 16'hFFFF, 16'h0000, 1'b0);
        add_cell(4'h0, 4'hF, 8'h33, 16'hFFFF, 16'hFFFF, 1'b1);
        // lone cell with end of screen
        add_cell(4'hA, 4'h5, 8'hC3, 16'hA5A5, 16'h5A5A, 1'b1);
        // full frame followed by end of screen in the same colors
        for (int i = 0; i < 7; i++)
            add_cell(4'(i), 4'h7, 8'(8'h41 + i), 16'h1234, 16'hFEDC, i == 6);
        drain();

        // random phases, one base setting each
        plan[0] = 32'h0000_0000;
        plan[1] = 32'h0000_0100;
        plan[2] = 32'($urandom_range(0, 11'h7FF));
        plan[3] = $urandom;
        plan[4] = 32'h0000_07FF;
        plan[5] = 32'h0000_0000;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_base(plan[p]);
            goal = cells_queued + CELLS_PER_PHASE;
            while (cells_queued < goal)
                queue_screen();
            drain();
        end

        $display("%0d cells packed into %0d checked frames, %0d cells closed two frames",
                 cells_taken, frames_checked, double_cells);
        $display("frame_id_base took %0d settings with both extremes; %0d mismatches",
                 base_settings, mismatches);
        if (mismatches == 0)
            $display("tb_text_cell_run_packer OK");
        else
            $display("tb_text_cell_run_packer NOT OK");
        $finish;
    end

endmodule
